@@ rtl/rbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbcc_pkg
// Shared types and constants for the relocation-blind code checksum block.
// ----------------------------------------------------------------------------
package rbcc_pkg;

    // Decoupling queue between the classifier and the accumulator
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] SEED_RESET   = 32'h0B112D28;
    localparam logic [WORD_W-1:0] ADJUST_RESET = 32'h002A4EB6;
    localparam logic [WORD_W-1:0] BASE_RESET   = SEED_RESET + ADJUST_RESET;

    // Opcode bits cleared from the JAL upper half
    localparam logic [HALF_W-1:0] JAL_OPC_MASK = 16'hFC00;

    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LW    = 6'h23;

    typedef enum logic {
        OP_START = 1'b0,
        OP_CODE  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED   = 1'b0,
        REG_ADJUST = 1'b1
    } cfg_reg_t;

    // One classified transaction: start loads the header, otherwise value
    // is the signed contribution of the code word to the running sum
    typedef struct packed {
        logic              start;
        logic              last;
        logic [WORD_W-1:0] value;
    } qentry_t;

endpackage

@@ rtl/relocation_blind_code_checksum_core.sv @@
// ----------------------------------------------------------------------------
// relocation_blind_code_checksum_core
// Checksum of a MIPS code stream that ignores relocatable immediates.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle on both sides while the queue is not
//   full and no result is stalled on m_tready; front and accumulator each
//   handle one word per clock. Path: a last word is written into the queue,
//   then popped into the result register that drives m_tdata.
// Reset (aresetn low, synchronous): queue empty, no result pending, sum,
//   previous word and header cleared, seed and adjust back to defaults.
module relocation_blind_code_checksum_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tuser,   // [0] op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] offset
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import rbcc_pkg::*;

    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] adjust_reg, adjust_next;
    logic [WORD_W-1:0] base_reg, base_next;

    logic    q_full, q_push, q_valid, q_pop;
    qentry_t q_in, q_head;

    always_comb begin
        seed_next   = seed_reg;
        adjust_next = adjust_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SEED:   seed_next   = cfg_wdata;
                REG_ADJUST: adjust_next = cfg_wdata;
                default:    ;
            endcase
        end
        base_next = seed_next + adjust_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= SEED_RESET;
            adjust_reg <= ADJUST_RESET;
            base_reg   <= BASE_RESET;
        end else begin
            seed_reg   <= seed_next;
            adjust_reg <= adjust_next;
            base_reg   <= base_next;
        end
    end

    rbcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    rbcc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    rbcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .base     (base_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/rbcc_front.sv @@
// ----------------------------------------------------------------------------
// rbcc_front
// Accepts input transactions, tracks the previous code word and reduces each
// word to its contribution to the running sum.
// ----------------------------------------------------------------------------
module rbcc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // [31:0] word
    input  logic                    s_tuser,   // [0] op
    input  logic                    s_tlast,
    input  logic                    q_full,
    output logic                    q_push,
    output rbcc_pkg::qentry_t       q_entry
);
    import rbcc_pkg::*;

    logic [WORD_W-1:0] prev_word_reg, prev_word_next;
    logic              accept;
    logic              is_start;
    logic [5:0]        opc;
    logic [4:0]        rs, rt, prev_rt;
    logic [HALF_W-1:0] hi, lo, prev_lo;
    logic              pair_hit;
    logic              jal_hit;
    logic [WORD_W-1:0] delta;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (s_tuser == OP_START);

    assign opc     = s_tdata[31:26];
    assign rs      = s_tdata[25:21];
    assign rt      = s_tdata[20:16];
    assign hi      = s_tdata[31:16];
    assign lo      = s_tdata[15:0];
    assign prev_rt = prev_word_reg[20:16];
    assign prev_lo = prev_word_reg[15:0];

    // LUI followed by ADDIU/LW on the same register: both immediates cancel
    assign pair_hit = (prev_word_reg[31:26] == OPC_LUI) &&
                      ((opc == OPC_ADDIU) || (opc == OPC_LW)) &&
                      (rs == prev_rt) && (rs == rt);
    assign jal_hit  = (opc == OPC_JAL);

    always_comb begin
        if (pair_hit) begin
            delta = {{HALF_W{1'b0}}, hi} - {{HALF_W{1'b0}}, prev_lo};
        end else if (jal_hit) begin
            delta = {{HALF_W{1'b0}}, hi & ~JAL_OPC_MASK};
        end else begin
            delta = {{HALF_W{1'b0}}, hi} + {{HALF_W{1'b0}}, lo};
        end
    end

    always_comb begin
        prev_word_next = prev_word_reg;
        if (accept) begin
            prev_word_next = is_start ? '0 : s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_word_reg <= '0;
        end else begin
            prev_word_reg <= prev_word_next;
        end
    end

    assign q_push        = accept;
    assign q_entry.start = is_start;
    assign q_entry.last  = s_tlast;
    assign q_entry.value = is_start ? s_tdata : delta;

endmodule

@@ rtl/rbcc_queue.sv @@
// ----------------------------------------------------------------------------
// rbcc_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rbcc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rbcc_pkg::qentry_t push_entry,
    output logic              full,
    output logic              valid,
    output rbcc_pkg::qentry_t head,
    input  logic              pop
);
    import rbcc_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

    qentry_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/rbcc_back.sv @@
// ----------------------------------------------------------------------------
// rbcc_back
// Folds queued contributions into header + sum and drives the result
// register.
// ----------------------------------------------------------------------------
module rbcc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  rbcc_pkg::qentry_t q_head,
    output logic              q_pop,
    input  logic [31:0]       base,      // seed + adjust
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata    // [31:0] offset
);
    import rbcc_pkg::*;

    // acc holds header + running sum, so offset = base - acc
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_free;
    logic [WORD_W-1:0] acc_upd;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_head.last || out_free);
    assign acc_upd  = q_head.start ? q_head.value : acc_reg + q_head.value;

    always_comb begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (q_pop) begin
            acc_next = acc_upd;
            if (q_head.last) begin
                out_valid_next = 1'b1;
                out_data_next  = base - acc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/rbcc_checker.sv @@
// ----------------------------------------------------------------------------
// rbcc_checker
// Port-level checks on the checksum core, attached by bind.
// ----------------------------------------------------------------------------
module rbcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import rbcc_pkg::*;

    localparam int unsigned PEND_W = QCNT_W + 1;

    // results owed: last transactions accepted minus results delivered
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              s_last_acc, m_acc;

    assign s_last_acc = s_tvalid && s_tready && s_tlast;
    assign m_acc      = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (s_last_acc && !m_acc) begin
            pend_next = pend_reg + 1'b1;
        end else if (m_acc && !s_last_acc) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != '0)
        else $error("result without a last transaction");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_W'(QDEPTH + 1))
        else $error("more results owed than the core can hold");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind relocation_blind_code_checksum_core rbcc_checker u_rbcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
